>>> rtl/sphc_pkg.sv
// Package for the stepper position and homing controller.
// Types, codes, reset values and fixed-point helpers shared by every file.
// No dependencies.
package sphc_pkg;

  // Fixed-point format of the position register
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int DEG_W     = 16;
  localparam int INC_W     = 16;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Working width: holds a degree value moved up to the binary point,
  // a full position, and the difference of the two
  localparam int WIDE_W = ((DEG_W + FRAC_BITS) > POS_W ? DEG_W + FRAC_BITS : POS_W) + 2;

  // Shift that aligns the 0.16 increment register to FRAC_BITS
  localparam int INC_SHL = (FRAC_BITS >= INC_W) ? FRAC_BITS - INC_W : 0;
  localparam int INC_SHR = (FRAC_BITS <  INC_W) ? INC_W - FRAC_BITS : 0;

  // Bias that turns a floor shift into truncation toward zero
  localparam logic [WIDE_W-1:0] TRUNC_BIAS = WIDE_W'((64'd1 << FRAC_BITS) - 64'd1);

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Raw item kind codes
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GOTO       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENABLE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISABLE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWITCH     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SAVE_ZERO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR_ZERO = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALFSTEP_INC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_INIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TARGET  = 3'd4;

  // Reset values
  localparam logic signed [DEG_W-1:0] ANGLE_MIN_RESET = 16'sd0;
  localparam logic signed [DEG_W-1:0] ANGLE_MAX_RESET = 16'sd180;
  localparam logic [INC_W-1:0]        INC_RESET       = 16'd58982;
  localparam logic signed [DEG_W-1:0] TARGET_RESET    = 16'sd90;
  localparam logic signed [DEG_W-1:0] CORR_RESET      = 16'sd0;

  // Operation decoded by the front
  typedef enum logic [2:0] {
    OP_TICK,
    OP_GOTO,
    OP_ENABLE,
    OP_DISABLE,
    OP_SWITCH,
    OP_SAVE_ZERO,
    OP_CLEAR_ZERO,
    OP_NOP
  } op_t;

  // Classified command held in the queue
  typedef struct packed {
    op_t                      op;
    logic signed [DEG_W-1:0]  tgt;      // goto angle, already clamped
    logic                     sw;       // min switch level
  } cmd_t;

  // Live configuration seen by the back
  typedef struct packed {
    logic signed [DEG_W-1:0]  angle_min;
    logic signed [DEG_W-1:0]  angle_max;
    logic [INC_W-1:0]         inc;
  } cfg_t;

  // Queue status toward front and back
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // Result payload
  typedef struct packed {
    logic                     step_run;
    logic                     dir_up;
    logic                     driver_enable;
    logic                     ready_flag;
    logic                     homing_flag;
    logic signed [DEG_W-1:0]  position_deg;
    logic signed [DEG_W-1:0]  target_deg;
  } res_t;

  // Clamp: above max wins first, then below min
  function automatic logic signed [DEG_W-1:0] clamp_deg(
    input logic signed [DEG_W-1:0] p,
    input logic signed [DEG_W-1:0] lo,
    input logic signed [DEG_W-1:0] hi
  );
    if (p > hi) begin
      return hi;
    end else if (p < lo) begin
      return lo;
    end
    return p;
  endfunction

  // Position register as a signed working value
  function automatic logic signed [WIDE_W-1:0] pos_wide(input logic [POS_W-1:0] pos);
    return WIDE_W'($signed(pos));
  endfunction

  // Whole degrees moved up to the binary point, still wide
  function automatic logic signed [WIDE_W-1:0] deg_wide(input logic signed [DEG_W-1:0] d);
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(d);
    return w <<< FRAC_BITS;
  endfunction

  // Whole degrees as a position, wrapped to the position width
  function automatic logic [POS_W-1:0] deg_to_fx(input logic signed [DEG_W-1:0] d);
    logic signed [WIDE_W-1:0] w;
    w = deg_wide(d);
    return w[POS_W-1:0];
  endfunction

  // Truncate toward zero to whole degrees, keep the low degree bits
  function automatic logic signed [DEG_W-1:0] trunc_deg(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] b;
    b = v[WIDE_W-1] ? v + $signed(TRUNC_BIAS) : v;
    b = b >>> FRAC_BITS;
    return b[DEG_W-1:0];
  endfunction

  // Direction toward a target: 1 when the target lies above the position
  function automatic logic deg_up(
    input logic signed [DEG_W-1:0] p,
    input logic [POS_W-1:0]        pos
  );
    return deg_wide(p) > pos_wide(pos);
  endfunction

  // Half-step increment aligned to the position format
  function automatic logic [POS_W-1:0] inc_fx(input logic [INC_W-1:0] inc);
    logic [POS_W-1:0] w;
    w = POS_W'(inc);
    return (w << INC_SHL) >> INC_SHR;
  endfunction

endpackage

>>> rtl/sphc_ifs.sv
// Channel interfaces of the stepper position and homing controller.
// Depends on sphc_pkg for field widths.
interface sphc_in_if;
  logic                              valid;
  logic                              ready;
  logic [sphc_pkg::KIND_W-1:0]       kind;
  logic signed [sphc_pkg::DEG_W-1:0] target_angle;
  logic                              min_switch;

  modport source (output valid, kind, target_angle, min_switch, input ready);
  modport sink   (input valid, kind, target_angle, min_switch, output ready);
endinterface

interface sphc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              step_run;
  logic                              dir_up;
  logic                              driver_enable;
  logic                              ready_flag;
  logic                              homing_flag;
  logic signed [sphc_pkg::DEG_W-1:0] position_deg;
  logic signed [sphc_pkg::DEG_W-1:0] target_deg;

  modport source (output valid, step_run, dir_up, driver_enable, ready_flag, homing_flag,
                  position_deg, target_deg, input ready);
  modport sink   (input valid, step_run, dir_up, driver_enable, ready_flag, homing_flag,
                  position_deg, target_deg, output ready);
endinterface

>>> rtl/sphc_front.sv
// Front of the controller: configuration registers, item decode and goto clamp.
// Depends on sphc_pkg and sphc_in_if; feeds sphc_queue.
module sphc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  sphc_in_if.sink                            in_ch,
  input  logic                               cfg_we,
  input  logic [sphc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sphc_pkg::CFG_W-1:0]         cfg_data,
  input  sphc_pkg::q_stat_t                  q_stat,
  output logic                               push,
  output sphc_pkg::cmd_t                     push_cmd,
  output sphc_pkg::cfg_t                     cfg
);
  import sphc_pkg::*;

  logic signed [DEG_W-1:0] angle_min_r;
  logic signed [DEG_W-1:0] angle_max_r;
  logic [INC_W-1:0]        inc_r;
  op_t                     op;

  // Configuration writes; writes to the correction and target reset registers are
  // ignored, and the back uses their reset values directly at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_min_r <= ANGLE_MIN_RESET;
      angle_max_r <= ANGLE_MAX_RESET;
      inc_r       <= INC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_MIN:    angle_min_r <= $signed(cfg_data[DEG_W-1:0]);
        CFG_ANGLE_MAX:    angle_max_r <= $signed(cfg_data[DEG_W-1:0]);
        CFG_HALFSTEP_INC: inc_r       <= cfg_data[INC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.angle_min = angle_min_r;
  assign cfg.angle_max = angle_max_r;
  assign cfg.inc       = inc_r;

  // Decode the raw kind
  always_comb begin
    unique case (in_ch.kind)
      KIND_TICK:       op = OP_TICK;
      KIND_GOTO:       op = OP_GOTO;
      KIND_ENABLE:     op = OP_ENABLE;
      KIND_DISABLE:    op = OP_DISABLE;
      KIND_SWITCH:     op = OP_SWITCH;
      KIND_SAVE_ZERO:  op = OP_SAVE_ZERO;
      KIND_CLEAR_ZERO: op = OP_CLEAR_ZERO;
      default:         op = OP_NOP;
    endcase
  end

  // Transfer into the queue whenever it has room
  assign in_ch.ready  = !q_stat.full;
  assign push         = in_ch.valid && !q_stat.full;
  assign push_cmd.op  = op;
  assign push_cmd.tgt = clamp_deg(in_ch.target_angle, angle_min_r, angle_max_r);
  assign push_cmd.sw  = in_ch.min_switch;

endmodule

>>> rtl/sphc_queue.sv
// Short command queue between the front and the back.
// Depends on sphc_pkg for the command type and depth.
module sphc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sphc_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output sphc_pkg::cmd_t     head,
  output sphc_pkg::q_stat_t  q_stat
);
  import sphc_pkg::*;

  cmd_t               ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the payload
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = ent_r[rd_ptr_r];
  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));

  // Occupancy never goes past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  // Pop only from a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

endmodule

>>> rtl/sphc_back.sv
// Back of the controller: axis state update and the result register.
// Depends on sphc_pkg and sphc_out_if; drains sphc_queue.
module sphc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sphc_pkg::cfg_t     cfg,
  input  sphc_pkg::cmd_t     head,
  input  sphc_pkg::q_stat_t  q_stat,
  output logic               pop,
  sphc_out_if.source         out_ch
);
  import sphc_pkg::*;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [DEG_W-1:0] tgt_r, tgt_nxt;
  logic signed [DEG_W-1:0] corr_r, corr_nxt;
  logic                    dir_r, dir_nxt;
  logic                    run_r, run_nxt;
  logic                    hom_r, hom_nxt;
  logic                    en_r, en_nxt;
  logic                    rdy_r, rdy_nxt;
  logic                    out_valid_r;
  res_t                    res_r, res_nxt;

  logic                    do_sync;
  logic signed [DEG_W-1:0] p;
  logic signed [DEG_W-1:0] s;
  logic signed [DEG_W-1:0] pending;

  // Take the next command when the result register is free or being drained
  assign pop = q_stat.valid && (!out_valid_r || out_ch.ready);

  // State update: the command first, then at most one sync to the home angle
  always_comb begin
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    corr_nxt = corr_r;
    dir_nxt  = dir_r;
    run_nxt  = run_r;
    hom_nxt  = hom_r;
    en_nxt   = en_r;
    rdy_nxt  = rdy_r;
    do_sync  = 1'b0;
    p        = head.tgt;
    s        = '0;
    pending  = '0;

    unique case (head.op)
      OP_TICK: begin
        if (run_r && !hom_r) begin
          pos_nxt = dir_r ? pos_r + inc_fx(cfg.inc) : pos_r - inc_fx(cfg.inc);
          if (trunc_deg(pos_wide(pos_nxt)) == tgt_r) begin
            run_nxt = 1'b0;
            hom_nxt = 1'b0;
            rdy_nxt = 1'b1;
          end
        end
      end
      OP_GOTO: begin
        if (p != tgt_r) begin
          tgt_nxt = p;
          if (!hom_r) begin
            if ((p > tgt_r) != dir_r) begin
              run_nxt = 1'b0;
            end
            dir_nxt = deg_up(p, pos_r);
            if (head.sw && !dir_nxt) begin
              run_nxt = 1'b0;
              do_sync = 1'b1;
            end else begin
              run_nxt = 1'b1;
              rdy_nxt = 1'b0;
            end
          end
        end
      end
      OP_ENABLE: begin
        if (!en_r) begin
          en_nxt  = 1'b1;
          rdy_nxt = 1'b0;
          if (head.sw) begin
            do_sync = 1'b1;
          end else begin
            hom_nxt = 1'b1;
            dir_nxt = 1'b0;
            run_nxt = 1'b1;
          end
        end
      end
      OP_DISABLE: begin
        run_nxt = 1'b0;
        hom_nxt = 1'b0;
        en_nxt  = 1'b0;
        rdy_nxt = 1'b0;
      end
      OP_SWITCH: begin
        do_sync = head.sw && !dir_r;
      end
      OP_SAVE_ZERO: begin
        corr_nxt = trunc_deg(deg_wide(corr_r) - pos_wide(pos_r));
      end
      OP_CLEAR_ZERO: begin
        pos_nxt  = pos_r - deg_to_fx(corr_r);
        corr_nxt = '0;
      end
      OP_NOP: ;
      default: ;
    endcase

    // Sync: stop, set position to home plus correction, resume to pending target
    if (do_sync) begin
      pending = tgt_nxt;
      s       = cfg.angle_min + corr_nxt;
      run_nxt = 1'b0;
      hom_nxt = 1'b0;
      pos_nxt = deg_to_fx(s);
      tgt_nxt = s;
      p       = clamp_deg(pending, cfg.angle_min, cfg.angle_max);
      if (p != s) begin
        tgt_nxt = p;
        dir_nxt = deg_up(p, pos_nxt);
        if (!(head.sw && !dir_nxt)) begin
          run_nxt = 1'b1;
          rdy_nxt = 1'b0;
        end
      end
    end
  end

  // Result fields after the update
  always_comb begin
    res_nxt.step_run      = run_nxt;
    res_nxt.dir_up        = dir_nxt;
    res_nxt.driver_enable = en_nxt;
    res_nxt.ready_flag    = rdy_nxt;
    res_nxt.homing_flag   = hom_nxt;
    res_nxt.position_deg  = trunc_deg(pos_wide(pos_nxt));
    res_nxt.target_deg    = tgt_nxt;
  end

  // Axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tgt_r  <= TARGET_RESET;
      corr_r <= CORR_RESET;
      dir_r  <= 1'b0;
      run_r  <= 1'b0;
      hom_r  <= 1'b0;
      en_r   <= 1'b0;
      rdy_r  <= 1'b0;
    end else if (pop) begin
      pos_r  <= pos_nxt;
      tgt_r  <= tgt_nxt;
      corr_r <= corr_nxt;
      dir_r  <= dir_nxt;
      run_r  <= run_nxt;
      hom_r  <= hom_nxt;
      en_r   <= en_nxt;
      rdy_r  <= rdy_nxt;
    end
  end

  // Result register: load on pop, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_run      = res_r.step_run;
  assign out_ch.dir_up        = res_r.dir_up;
  assign out_ch.driver_enable = res_r.driver_enable;
  assign out_ch.ready_flag    = res_r.ready_flag;
  assign out_ch.homing_flag   = res_r.homing_flag;
  assign out_ch.position_deg  = res_r.position_deg;
  assign out_ch.target_deg    = res_r.target_deg;

  // A running axis has not reached its target
  a_run_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && rdy_r))
    else $error("run and ready both set");

  // Homing only on an enabled axis moving down
  a_homing_down: assert property (@(posedge clk) disable iff (!rst_n)
    hom_r |-> (en_r && !dir_r))
    else $error("homing while disabled or moving up");

  // A waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !pop)
    else $error("result register overwritten while stalled");

endmodule

>>> rtl/stepper_position_homing_ctrl.sv
// Top level of the stepper position and homing controller.
// Depends on sphc_pkg, sphc_ifs, sphc_front, sphc_queue and sphc_back.
//
//   channel  direction  handshake        payload
//   in_ch    in         valid / ready    kind, target_angle, min_switch
//   out_ch   out        valid / ready    step_run, dir_up, driver_enable, ready_flag,
//                                        homing_flag, position_deg, target_deg
//   cfg      in         cfg_we           cfg_index, cfg_data (16 bits)
//
// One item a cycle sustained while out_ch is ready. After its input transfer an item is
// written into the queue, then the combinational state update in the back loads its
// result into the result register, from which it is offered on out_ch.
// A two-entry command queue sits between front and back; while a result waits, in_ch
// keeps accepting until both entries are taken.
// Reset is synchronous and active low; no clearing pass.
// A stalled out_ch backs up the queue, which then drops in_ch.ready.
module stepper_position_homing_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  sphc_in_if.sink                         in_ch,
  sphc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sphc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sphc_pkg::CFG_W-1:0]      cfg_data
);
  import sphc_pkg::*;

  cfg_t    cfg;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  sphc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd),
    .cfg       (cfg)
  );

  sphc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  sphc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
